// ===== hw/rtl/pid_pkg.sv =====
// Shared types and constants of the prefixed integer decoder.
`default_nettype none

package pid_pkg;

    localparam int VALUE_W     = 62;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 4;
    localparam int PREFIX_W    = 4;
    localparam int ACC_W       = 64;
    localparam int SHIFT_W     = 6;

    // Largest value that a finished integer may hold is 2^VALUE_BITS - 1.
    localparam int VALUE_BITS  = 62;
    // Bound on the continuation-byte count of one integer; SAFE_SHIFT caps it sooner, at 9.
    localparam int MAX_CONT    = 10;

    localparam logic [SHIFT_W-1:0]  SAFE_SHIFT   = 6'd56;
    localparam logic [SHIFT_W-1:0]  SHIFT_STEP   = 6'd7;
    localparam logic [PREFIX_W-1:0] PREFIX_MIN   = 4'd3;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX   = 4'd8;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 4'd8;
    localparam logic [7:0]          CONT_FLAG    = 8'h80;
    localparam logic [7:0]          PAYLOAD_MASK = 8'h7F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_ERROR      = 2'd2
    } status_t;

    typedef struct packed {
        logic       last_available;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bytes_consumed;
        status_t            status;
        logic [VALUE_W-1:0] decoded_value;
    } result_t;

endpackage : pid_pkg

`default_nettype wire

// ===== hw/rtl/prefix_integer_decoder.sv =====
// Top level of the prefixed integer decoder (HPACK/QPACK integer representation).
// A byte that completes an integer has its result loaded into the result register,
// which shows it on m_tvalid and holds it. Throughput: one byte per cycle unless the
// result register is full and not being read, set by the single decode step between
// the input and result registers. Reset (aresetn low at a clock edge) empties both
// registers, drops any partial integer and sets the prefix width back to 8.
`default_nettype none

module prefix_integer_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: the prefix width, the number of low bits of a first byte
    // that carry the prefix.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,

    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_available

    // Decoded integers out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [61:0] decoded_value, [63:62] status,
                                        // [67:64] bytes_consumed, [71:68] zero
);
    import pid_pkg::*;

    logic [PREFIX_W-1:0] prefix_width_reg;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    // The register may be written at any time; the design expects writes only
    // while no integer is in flight, and the new width governs the next first byte.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_width_reg <= PREFIX_RESET;
        end else if (cfg_valid) begin
            prefix_width_reg <= cfg_data;
        end
    end

    assign s_item.data_byte      = s_tdata;
    assign s_item.last_available = s_tlast;

    // The held byte is decoded whenever the result register can take what it
    // produces: either that register is empty or its transaction completes now.
    // A byte that produces no result still moves on in the same way.
    assign advance = item_valid && (!m_tvalid || m_tready);

    pid_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pid_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .prefix_width (prefix_width_reg),
        .advance      (advance),
        .item         (item),
        .res_valid    (res_valid),
        .res          (res)
    );

    pid_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata = {4'd0, m_res};

endmodule : prefix_integer_decoder

`default_nettype wire

// ===== hw/rtl/pid_in_reg.sv =====
// Input register stage holding one accepted byte until the decoder takes it.
`default_nettype none

module pid_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pid_pkg::in_item_t s_item,
    input  wire logic             advance,
    output logic                  item_valid,
    output pid_pkg::in_item_t     item
);
    import pid_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The slot frees up in the same cycle as its byte moves on.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule : pid_in_reg

`default_nettype wire

// ===== hw/rtl/pid_core.sv =====
// Decode state and the single-pass byte step of the prefixed integer decoder.
`default_nettype none

module pid_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [pid_pkg::PREFIX_W-1:0]     prefix_width,
    input  wire logic                             advance,
    input  wire pid_pkg::in_item_t                item,
    output logic                                  res_valid,
    output pid_pkg::result_t                      res
);
    import pid_pkg::*;

    logic               in_cont_reg,    in_cont_next;
    logic [ACC_W-1:0]   acc_reg,        acc_next;
    logic [SHIFT_W-1:0] shift_reg,      shift_next;
    logic [COUNT_W-1:0] count_reg,      count_next;

    logic [8:0]         prefix_one;
    logic [7:0]         prefix_mask;
    logic [7:0]         prefix_val;
    logic [COUNT_W-1:0] count_inc;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W:0]     sum;
    logic               prefix_bad;

    assign prefix_one  = 9'd1 << prefix_width;
    assign prefix_mask = 8'(prefix_one - 9'd1);
    assign prefix_val  = item.data_byte & prefix_mask;
    assign prefix_bad  = (prefix_width < PREFIX_MIN) || (prefix_width > PREFIX_MAX);

    assign count_inc = count_reg + 4'd1;
    assign addend    = ACC_W'(item.data_byte & PAYLOAD_MASK) << shift_reg;
    assign sum       = {1'b0, acc_reg} + {1'b0, addend};

    always_comb begin
        in_cont_next       = in_cont_reg;
        acc_next           = acc_reg;
        shift_next         = shift_reg;
        count_next         = count_reg;
        res_valid          = 1'b0;
        res.decoded_value  = '0;
        res.status         = ST_OK;
        res.bytes_consumed = count_inc;

        if (!in_cont_reg) begin
            res.bytes_consumed = 4'd1;
            if (prefix_bad) begin
                res_valid  = 1'b1;
                res.status = ST_ERROR;
            end else if (prefix_val < prefix_mask) begin
                res_valid         = 1'b1;
                res.decoded_value = VALUE_W'(prefix_val);
            end else if (item.last_available) begin
                res_valid  = 1'b1;
                res.status = ST_INCOMPLETE;
            end else begin
                in_cont_next = 1'b1;
                acc_next     = ACC_W'(prefix_val);
                shift_next   = '0;
                count_next   = 4'd1;
            end
        end else begin
            if (count_reg > COUNT_W'(MAX_CONT) || shift_reg > SAFE_SHIFT || sum[ACC_W]) begin
                res_valid  = 1'b1;
                res.status = ST_ERROR;
            end else if ((item.data_byte & CONT_FLAG) != 8'd0) begin
                acc_next   = sum[ACC_W-1:0];
                shift_next = shift_reg + SHIFT_STEP;
                count_next = count_inc;
                if (item.last_available) begin
                    res_valid  = 1'b1;
                    res.status = ST_INCOMPLETE;
                end
            end else begin
                res_valid = 1'b1;
                if ((sum[ACC_W-1:0] >> VALUE_BITS) != '0) begin
                    res.status = ST_ERROR;
                end else begin
                    res.decoded_value = sum[VALUE_W-1:0];
                end
            end
        end

        // Any result ends the integer.
        if (res_valid) begin
            in_cont_next = 1'b0;
            acc_next     = '0;
            shift_next   = '0;
            count_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cont_reg <= 1'b0;
            acc_reg     <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
        end else if (advance) begin
            in_cont_reg <= in_cont_next;
            acc_reg     <= acc_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
        end
    end

endmodule : pid_core

`default_nettype wire

// ===== hw/rtl/pid_out_reg.sv =====
// Result register presenting one decoded integer on the output stream.
`default_nettype none

module pid_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire pid_pkg::result_t res,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pid_pkg::result_t      m_res
);
    import pid_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule : pid_out_reg

`default_nettype wire
